// ----- hdl/sactl_pkg.sv -----
// Shared constants, types and configuration register codes for the tag lookup block.
package sactl_pkg;

  localparam int unsigned SETS       = 256;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned ADDR_WIDTH = 32;
  localparam int unsigned SET_W      = $clog2(SETS);
  localparam int unsigned WAY_W      = $clog2(WAYS);
  localparam int unsigned WCNT_W     = $clog2(WAYS + 1);
  localparam int unsigned CNT_W      = 32;

  localparam int unsigned OFF_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned ABITS_W    = 6;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [OFF_W-1:0]   OFFSET_BITS_RST = OFF_W'(2);
  localparam logic [IDX_W-1:0]   INDEX_BITS_RST  = IDX_W'(8);
  localparam logic [WCNT_W-1:0]  WAYS_RST        = WCNT_W'(4);
  localparam logic [ABITS_W-1:0] ADDR_BITS_RST   = ABITS_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2,
    CFG_ADDR_BITS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WAY_W-1:0]                 ptr;
    logic [WAYS-1:0]                  valid;
    logic [WAYS-1:0][ADDR_WIDTH-1:0]  tag;
  } row_t;

  typedef struct packed {
    logic [SET_W-1:0]      set;
    logic [ADDR_WIDTH-1:0] tag;
  } lookup_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    row_t             row_n;
  } match_t;

endpackage

// ----- hdl/sactl_if.sv -----
// Request and response channel interfaces for the tag lookup block.
interface sactl_req_if;
  logic                                valid;
  logic                                ready;
  logic [sactl_pkg::ADDR_WIDTH-1:0]    address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sactl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [1:0]                        way_used;
  logic [sactl_pkg::CNT_W-1:0]       request_count;
  logic [sactl_pkg::CNT_W-1:0]       hit_count;
  logic [sactl_pkg::CNT_W-1:0]       miss_count;

  modport source (output valid, output hit, output way_used, output request_count,
                  output hit_count, output miss_count, input ready);
  modport sink   (input valid, input hit, input way_used, input request_count,
                  input hit_count, input miss_count, output ready);
endinterface

// ----- hdl/sactl_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module sactl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sactl_addr_decode.sv -----
// Address split into set index and tag from the configured field widths.
module sactl_addr_decode (
  input  logic [sactl_pkg::ADDR_WIDTH-1:0] address_i,
  input  logic [sactl_pkg::OFF_W-1:0]      offset_bits_i,
  input  logic [sactl_pkg::IDX_W-1:0]      index_bits_i,
  input  logic [sactl_pkg::ABITS_W-1:0]    addr_bits_i,
  output sactl_pkg::lookup_t               lookup_o
);

  logic [sactl_pkg::ABITS_W-1:0]   width;
  logic [sactl_pkg::SHIFT_W-1:0]   low;
  logic [sactl_pkg::ADDR_WIDTH:0]  width_mask;
  logic [sactl_pkg::ADDR_WIDTH-1:0] masked;
  logic [sactl_pkg::ADDR_WIDTH-1:0] shifted;
  logic [sactl_pkg::SET_W:0]       set_mask_wide;
  logic [sactl_pkg::SET_W-1:0]     set_mask;

  always_comb begin
    width = (addr_bits_i > sactl_pkg::ABITS_W'(sactl_pkg::ADDR_WIDTH))
          ? sactl_pkg::ABITS_W'(sactl_pkg::ADDR_WIDTH) : addr_bits_i;
    low = sactl_pkg::SHIFT_W'(offset_bits_i) + sactl_pkg::SHIFT_W'(index_bits_i);
    width_mask = ((sactl_pkg::ADDR_WIDTH+1)'(1) << width) - (sactl_pkg::ADDR_WIDTH+1)'(1);
    masked = address_i & width_mask[sactl_pkg::ADDR_WIDTH-1:0];
    lookup_o.tag = masked >> low;

    shifted = address_i >> offset_bits_i;
    set_mask_wide = ((sactl_pkg::SET_W+1)'(1) << index_bits_i) - (sactl_pkg::SET_W+1)'(1);
    set_mask = (32'(index_bits_i) >= sactl_pkg::SET_W) ? '1
             : set_mask_wide[sactl_pkg::SET_W-1:0];
    lookup_o.set = shifted[sactl_pkg::SET_W-1:0] & set_mask;
  end

endmodule

// ----- hdl/sactl_way_match.sv -----
// Parallel tag compare across the ways of one set and round-robin victim update.
module sactl_way_match (
  input  sactl_pkg::row_t                   row_i,
  input  logic [sactl_pkg::ADDR_WIDTH-1:0]  tag_i,
  input  logic [sactl_pkg::WCNT_W-1:0]      ways_in_use_i,
  output sactl_pkg::match_t                 match_o
);

  logic [sactl_pkg::WCNT_W-1:0] ways;
  logic [sactl_pkg::WAY_W-1:0]  victim;
  logic [sactl_pkg::WCNT_W-1:0] victim_inc;

  always_comb begin
    if (ways_in_use_i == '0) begin
      ways = sactl_pkg::WCNT_W'(1);
    end else if (ways_in_use_i > sactl_pkg::WCNT_W'(sactl_pkg::WAYS)) begin
      ways = sactl_pkg::WCNT_W'(sactl_pkg::WAYS);
    end else begin
      ways = ways_in_use_i;
    end

    match_o.hit = 1'b0;
    match_o.way = '0;
    for (int w = sactl_pkg::WAYS - 1; w >= 0; w--) begin
      if ((sactl_pkg::WCNT_W'(w) < ways) && row_i.valid[w] && (row_i.tag[w] == tag_i)) begin
        match_o.hit = 1'b1;
        match_o.way = sactl_pkg::WAY_W'(w);
      end
    end

    victim = (sactl_pkg::WCNT_W'(row_i.ptr) >= ways) ? '0 : row_i.ptr;
    victim_inc = sactl_pkg::WCNT_W'(victim) + sactl_pkg::WCNT_W'(1);

    match_o.row_n = row_i;
    if (!match_o.hit) begin
      match_o.way = victim;
      match_o.row_n.tag[victim] = tag_i;
      match_o.row_n.valid[victim] = 1'b1;
      match_o.row_n.ptr = (victim_inc >= ways) ? '0 : victim_inc[sactl_pkg::WAY_W-1:0];
    end
  end

endmodule

// ----- hdl/set_assoc_cache_tag_lookup_core.sv -----
// Top level of the set-associative tag lookup with round-robin replacement.
// A request is registered into the lookup stage, then its result into the response register.
// One request per cycle unless the response is held; each reads and writes the row RAM once.
// A write to the row being read is forwarded from the last-write register.
// Reset: per-set valid flops clear at once (no clearing pass), counters go to zero,
// and the configuration registers return to their defaults.
module set_assoc_cache_tag_lookup_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sactl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sactl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sactl_req_if.sink                           req_i,
  sactl_rsp_if.source                         rsp_o
);

  logic [sactl_pkg::OFF_W-1:0]   offset_bits_q;
  logic [sactl_pkg::IDX_W-1:0]   index_bits_q;
  logic [sactl_pkg::WCNT_W-1:0]  ways_in_use_q;
  logic [sactl_pkg::ABITS_W-1:0] addr_bits_q;

  sactl_pkg::lookup_t            dec;
  sactl_pkg::match_t             match;
  sactl_pkg::row_t               ram_rdata;
  sactl_pkg::row_t               row_cur;

  logic                          accept;
  logic                          out_free;
  logic                          s1_fire;

  logic                          s1_valid_q;
  logic [sactl_pkg::SET_W-1:0]   s1_set_q;
  logic [sactl_pkg::ADDR_WIDTH-1:0] s1_tag_q;
  logic                          s1_rowv_q;

  logic [sactl_pkg::SETS-1:0]    row_valid_q;
  logic                          lw_valid_q;
  logic [sactl_pkg::SET_W-1:0]   lw_set_q;
  sactl_pkg::row_t               lw_row_q;

  logic [sactl_pkg::CNT_W-1:0]   req_cnt_q;
  logic [sactl_pkg::CNT_W-1:0]   hit_cnt_q;
  logic [sactl_pkg::CNT_W-1:0]   miss_cnt_q;
  logic [sactl_pkg::CNT_W-1:0]   req_cnt_d;
  logic [sactl_pkg::CNT_W-1:0]   hit_cnt_d;
  logic [sactl_pkg::CNT_W-1:0]   miss_cnt_d;

  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [1:0]                    out_way_q;
  logic [sactl_pkg::CNT_W-1:0]   out_req_q;
  logic [sactl_pkg::CNT_W-1:0]   out_hit_cnt_q;
  logic [sactl_pkg::CNT_W-1:0]   out_miss_cnt_q;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= sactl_pkg::OFFSET_BITS_RST;
      index_bits_q  <= sactl_pkg::INDEX_BITS_RST;
      ways_in_use_q <= sactl_pkg::WAYS_RST;
      addr_bits_q   <= sactl_pkg::ADDR_BITS_RST;
    end else if (cfg_we_i) begin
      case (sactl_pkg::cfg_idx_e'(cfg_idx_i))
        sactl_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[sactl_pkg::OFF_W-1:0];
        sactl_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i[sactl_pkg::IDX_W-1:0];
        sactl_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i[sactl_pkg::WCNT_W-1:0];
        sactl_pkg::CFG_ADDR_BITS:   addr_bits_q   <= cfg_data_i[sactl_pkg::ABITS_W-1:0];
        default: ;
      endcase
    end
  end

  sactl_addr_decode u_decode (
    .address_i     (req_i.address),
    .offset_bits_i (offset_bits_q),
    .index_bits_i  (index_bits_q),
    .addr_bits_i   (addr_bits_q),
    .lookup_o      (dec)
  );

  sactl_ram #(
    .WIDTH ($bits(sactl_pkg::row_t)),
    .DEPTH (sactl_pkg::SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_set_q),
    .wdata_i (match.row_n),
    .re_i    (accept),
    .raddr_i (dec.set),
    .rdata_o (ram_rdata)
  );

  // take the newest copy of the row: last write, else RAM, else cleared row
  always_comb begin
    if (lw_valid_q && (lw_set_q == s1_set_q)) begin
      row_cur = lw_row_q;
    end else if (s1_rowv_q) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  sactl_way_match u_match (
    .row_i         (row_cur),
    .tag_i         (s1_tag_q),
    .ways_in_use_i (ways_in_use_q),
    .match_o       (match)
  );

  always_comb begin
    req_cnt_d  = req_cnt_q + sactl_pkg::CNT_W'(1);
    hit_cnt_d  = match.hit ? hit_cnt_q + sactl_pkg::CNT_W'(1) : hit_cnt_q;
    miss_cnt_d = match.hit ? miss_cnt_q : miss_cnt_q + sactl_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      row_valid_q <= '0;
      lw_valid_q  <= 1'b0;
      req_cnt_q   <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        row_valid_q[s1_set_q] <= 1'b1;
        lw_valid_q            <= 1'b1;
        req_cnt_q             <= req_cnt_d;
        hit_cnt_q             <= hit_cnt_d;
        miss_cnt_q            <= miss_cnt_d;
        out_valid_q           <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_set_q  <= dec.set;
      s1_tag_q  <= dec.tag;
      s1_rowv_q <= row_valid_q[dec.set];
    end
    if (s1_fire) begin
      lw_set_q       <= s1_set_q;
      lw_row_q       <= match.row_n;
      out_hit_q      <= match.hit;
      out_way_q      <= 2'(match.way);
      out_req_q      <= req_cnt_d;
      out_hit_cnt_q  <= hit_cnt_d;
      out_miss_cnt_q <= miss_cnt_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.way_used      = out_way_q;
  assign rsp_o.request_count = out_req_q;
  assign rsp_o.hit_count     = out_hit_cnt_q;
  assign rsp_o.miss_count    = out_miss_cnt_q;

  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> rsp_o.valid)
    else $error("processed lookup did not reach the response register");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (sactl_pkg::CNT_W'(rsp_o.hit_count + rsp_o.miss_count)
                     == rsp_o.request_count))
    else $error("hit and miss counts do not add up to request count");

  a_miss_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !match.hit) |-> match.row_n.valid[match.way])
    else $error("miss did not mark the filled way valid");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("request stalled without a held lookup and response");

endmodule
